// ----- hw/rtl/uartbe_pkg.sv -----
// Package for the UART bit engine: word types, register indexes and
// framing constants. No dependencies; imported by all but the checker.
package uartbe_pkg;

  localparam int unsigned CFG_ADDR_W = 1;

  localparam logic [CFG_ADDR_W-1:0] CFG_BIT_CYCLES  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INVERT_LINE = 1'd1;

  localparam logic [15:0] BIT_CYCLES_RESET = 16'd694;

  // Two stop bits sit above the eight data bits in the transmit shifter.
  localparam logic [9:0] TX_STOP_MASK  = 10'h300;
  localparam logic [3:0] TX_LAST_PHASE = 4'd11;
  localparam logic [3:0] RX_LAST_PHASE = 4'd9;

  typedef struct packed {
    logic [15:0] bit_cycles;
    logic        invert_line;
  } cfg_t;

  typedef struct packed {
    logic       rx_line;
    logic       tx_load;
    logic [7:0] tx_byte;
  } tick_t;

  typedef struct packed {
    logic       tx_line;
    logic       tx_busy;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } result_t;

endpackage

// ----- hw/rtl/uartbe_if.sv -----
// Handshake channel interfaces for the UART bit engine: tick input, result
// output and configuration write. Depends on uartbe_pkg.
interface uartbe_tick_if;
  logic       valid;
  logic       ready;
  logic       rx_line;
  logic       tx_load;
  logic [7:0] tx_byte;

  modport source (output valid, output rx_line, output tx_load, output tx_byte,
                  input ready);
  modport sink (input valid, input rx_line, input tx_load, input tx_byte,
                output ready);
endinterface

interface uartbe_result_if;
  logic       valid;
  logic       ready;
  logic       tx_line;
  logic       tx_busy;
  logic       rx_valid;
  logic [7:0] rx_byte;

  modport source (output valid, output tx_line, output tx_busy, output rx_valid,
                  output rx_byte, input ready);
  modport sink (input valid, input tx_line, input tx_busy, input rx_valid,
                input rx_byte, output ready);
endinterface

interface uartbe_cfg_if;
  import uartbe_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [15:0]           data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

// ----- hw/rtl/uart_tx_rx_bit_engine_core.sv -----
// Top level of the UART 8N2 bit engine: channel handshakes, configuration
// registers, input stage and result register around uartbe_engine.
// Depends on uartbe_pkg, uartbe_if.sv and uartbe_engine.
// A tick word goes from the input stage through the engine to the result register.
// Throughput: one tick word per cycle (one engine state update) unless stalled.
// Synchronous reset resets the valid flags, engine state and config registers.
module uart_tx_rx_bit_engine_core (
  input  logic                   clk,
  input  logic                   rst,
  uartbe_tick_if.sink            tick_in,
  uartbe_result_if.source        result_out,
  uartbe_cfg_if.sink             cfg
);
  import uartbe_pkg::*;

  cfg_t    cfg_reg;
  logic    stage_valid;
  tick_t   stage_word;
  logic    out_valid;
  result_t out_word;
  result_t engine_result;
  logic    advance;

  assign advance       = stage_valid && (!out_valid || result_out.ready);
  assign tick_in.ready = !stage_valid || advance;
  assign cfg.ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.bit_cycles  <= BIT_CYCLES_RESET;
      cfg_reg.invert_line <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.addr)
        CFG_BIT_CYCLES:  cfg_reg.bit_cycles  <= cfg.data;
        CFG_INVERT_LINE: cfg_reg.invert_line <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (tick_in.ready) begin
      stage_valid <= tick_in.valid;
    end
    if (tick_in.valid && tick_in.ready) begin
      stage_word.rx_line <= tick_in.rx_line;
      stage_word.tx_load <= tick_in.tx_load;
      stage_word.tx_byte <= tick_in.tx_byte;
    end
  end

  uartbe_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .cfg    (cfg_reg),
    .tick   (stage_word),
    .result (engine_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_word <= engine_result;
    end
  end

  assign result_out.valid    = out_valid;
  assign result_out.tx_line  = out_word.tx_line;
  assign result_out.tx_busy  = out_word.tx_busy;
  assign result_out.rx_valid = out_word.rx_valid;
  assign result_out.rx_byte  = out_word.rx_byte;

endmodule

// ----- hw/rtl/uartbe_engine.sv -----
// Transmit and receive bit state of the UART engine. Holds the timers,
// phases and shifters and computes one tick's result. Depends on uartbe_pkg.
module uartbe_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  uartbe_pkg::cfg_t    cfg,
  input  uartbe_pkg::tick_t   tick,
  output uartbe_pkg::result_t result
);
  import uartbe_pkg::*;

  logic        tx_pending, tx_pending_next;
  logic [3:0]  tx_phase, tx_phase_next;
  logic [9:0]  tx_shift, tx_shift_next;
  logic [15:0] tx_timer, tx_timer_next;
  logic        tx_level, tx_level_next;
  logic [3:0]  rx_phase, rx_phase_next;
  logic [7:0]  rx_shift, rx_shift_next;
  logic [16:0] rx_timer, rx_timer_next;

  logic [3:0]  tx_phase_inc;
  logic        rx_bit;
  logic [2:0]  rx_bit_idx;
  logic        rx_done;

  assign tx_phase_inc = tx_phase + 4'd1;
  assign rx_bit       = tick.rx_line ^ cfg.invert_line;
  assign rx_bit_idx   = 3'(rx_phase - 4'd2);

  always_comb begin
    tx_pending_next = tx_pending;
    tx_phase_next   = tx_phase;
    tx_shift_next   = tx_shift;
    tx_timer_next   = tx_timer;
    tx_level_next   = tx_level;

    if (tx_phase == 4'd0) begin
      if (tx_pending) begin
        // Start bit: the level is low before inversion.
        tx_shift_next = tx_shift | TX_STOP_MASK;
        tx_timer_next = cfg.bit_cycles;
        tx_level_next = cfg.invert_line;
        tx_phase_next = 4'd1;
      end
    end else if (tx_timer <= 16'd1) begin
      if (tx_phase_inc > TX_LAST_PHASE) begin
        tx_pending_next = 1'b0;
        tx_phase_next   = 4'd0;
        tx_timer_next   = 16'd0;
      end else begin
        tx_phase_next = tx_phase_inc;
        tx_level_next = tx_shift[0] ^ cfg.invert_line;
        tx_shift_next = tx_shift >> 1;
        tx_timer_next = cfg.bit_cycles;
      end
    end else begin
      tx_timer_next = tx_timer - 16'd1;
    end

    // A new byte is taken only once the previous one has fully gone out.
    if (!tx_pending_next && tick.tx_load) begin
      tx_pending_next = 1'b1;
      tx_shift_next   = {2'b00, tick.tx_byte};
    end
  end

  always_comb begin
    rx_phase_next = rx_phase;
    rx_shift_next = rx_shift;
    rx_timer_next = rx_timer;
    rx_done       = 1'b0;

    if (rx_phase == 4'd0) begin
      if (rx_bit) begin
        rx_phase_next = 4'd1;
      end
    end else if (rx_phase == 4'd1) begin
      if (!rx_bit) begin
        // Land in the middle of the first data bit, one and a half bits out.
        rx_shift_next = 8'd0;
        rx_phase_next = 4'd2;
        rx_timer_next = {1'b0, cfg.bit_cycles} + {2'b00, cfg.bit_cycles[15:1]};
      end
    end else if (rx_timer <= 17'd1) begin
      if (rx_phase > RX_LAST_PHASE) begin
        rx_phase_next = 4'd1;
        rx_timer_next = 17'd0;
        rx_done       = 1'b1;
      end else begin
        rx_shift_next[rx_bit_idx] = rx_shift[rx_bit_idx] | rx_bit;
        rx_timer_next = {1'b0, cfg.bit_cycles};
        rx_phase_next = rx_phase + 4'd1;
      end
    end else begin
      rx_timer_next = rx_timer - 17'd1;
    end
  end

  always_comb begin
    result.tx_line  = tx_level_next;
    result.tx_busy  = tx_pending_next;
    result.rx_valid = rx_done;
    result.rx_byte  = rx_done ? rx_shift_next : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_pending <= 1'b0;
      tx_phase   <= 4'd0;
      tx_shift   <= 10'd0;
      tx_timer   <= 16'd0;
      tx_level   <= 1'b1;
      rx_phase   <= 4'd0;
      rx_shift   <= 8'd0;
      rx_timer   <= 17'd0;
    end else if (step) begin
      tx_pending <= tx_pending_next;
      tx_phase   <= tx_phase_next;
      tx_shift   <= tx_shift_next;
      tx_timer   <= tx_timer_next;
      tx_level   <= tx_level_next;
      rx_phase   <= rx_phase_next;
      rx_shift   <= rx_shift_next;
      rx_timer   <= rx_timer_next;
    end
  end

endmodule

// ----- hw/rtl/uartbe_checker.sv -----
// Port-level checks for the UART bit engine top level, attached by bind.
// Depends only on the top level's ports.
module uartbe_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       tx_line,
  input logic       tx_busy,
  input logic       rx_valid,
  input logic [7:0] rx_byte
);

  // A result word with no received byte carries a zero byte field.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !rx_valid |-> rx_byte == 8'd0)
    else $error("rx_byte nonzero without rx_valid");

  // The result register is empty right after reset.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(tx_line) && $stable(tx_busy)
      && $stable(rx_valid) && $stable(rx_byte))
    else $error("result word changed while stalled");

endmodule

bind uart_tx_rx_bit_engine_core uartbe_checker u_uartbe_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .tx_line   (result_out.tx_line),
  .tx_busy   (result_out.tx_busy),
  .rx_valid  (result_out.rx_valid),
  .rx_byte   (result_out.rx_byte)
);
